FILE: rtl/core/picr_pkg.sv
// picr_pkg: shared types and constants of the pi current regulator
`timescale 1ns / 1ps

package picr_pkg;

   // mode codes as seen on the result word
   localparam logic [1:0] MODE_RUN   = 2'd0;
   localparam logic [1:0] MODE_FAULT = 2'd1;
   localparam logic [1:0] MODE_STOP  = 2'd2;

   // configuration register indexes
   localparam logic [2:0] CSR_CURRENT_LIMIT = 3'd0;
   localparam logic [2:0] CSR_BUS_VMIN      = 3'd1;
   localparam logic [2:0] CSR_BUS_VMAX      = 3'd2;
   localparam logic [2:0] CSR_PROP_GAIN     = 3'd3;
   localparam logic [2:0] CSR_INTEG_GAIN    = 3'd4;

   // configuration reset values
   localparam logic [14:0] CURRENT_LIMIT_RST = 15'd6400;
   localparam logic [15:0] BUS_VMIN_RST      = 16'd9728;
   localparam logic [15:0] BUS_VMAX_RST      = 16'd13312;
   localparam logic [15:0] PROP_GAIN_RST     = 16'd410;
   localparam logic [15:0] INTEG_GAIN_RST    = 16'd4096;

   // multiplier operand and product widths
   localparam int MUL_A_W = 19;
   localparam int MUL_B_W = 18;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // 36 V in q12.12, full duty, and ceil(2^14 / 9) for the divide by 9
   localparam logic signed [25:0] CLAMP_U     = 26'sd147456;
   localparam logic signed [23:0] CLAMP_INTEG = 24'sd147456;
   localparam logic signed [25:0] INTEG_MAX   = 26'sd8388607;
   localparam logic signed [25:0] INTEG_MIN   = -26'sd8388608;
   localparam logic [7:0]         DUTY_FULL   = 8'd150;
   localparam logic [17:0]        RECIP9      = 18'd1821;

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_EVAL = 9'b000000010,
      ST_MULI = 9'b000000100,
      ST_MULP = 9'b000001000,
      ST_SUM  = 9'b000010000,
      ST_MULD = 9'b000100000,
      ST_MULR = 9'b001000000,
      ST_DIV  = 9'b010000000,
      ST_OUT  = 9'b100000000
   } state_type;

endpackage

FILE: rtl/core/picr_mul.sv
// picr_mul: shared signed multiplier with registered product
`timescale 1ns / 1ps

module picr_mul (
   input  logic                                   clock,
   input  logic signed [picr_pkg::MUL_A_W-1:0]   op_a,
   input  logic signed [picr_pkg::MUL_B_W-1:0]   op_b,
   output logic signed [picr_pkg::MUL_P_W-1:0]   product
);

   logic signed [picr_pkg::MUL_P_W-1:0] product_ff;
   logic signed [picr_pkg::MUL_P_W-1:0] product_in;

   assign product_in = op_a * op_b;
   assign product    = product_ff;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule

FILE: rtl/core/pi_current_regulator_with_fault_latch_core.sv
// pi_current_regulator_with_fault_latch_core: pi current loop with overcurrent latch
// steps from req accept to rsp valid: eval and out in fault or stop mode; eval, muli,
// mulp, sum and out in run mode when the command clamps; else muld, mulr and div follow
// sum; out holds while a result is stalled. a word is taken only in idle, and the
// sequencer runs the integral, proportional and duty scaling products on one multiplier
// reset: synchronous; mode stop, integral, held duty and lamp cleared, registers to defaults
`timescale 1ns / 1ps

module pi_current_regulator_with_fault_latch_core (
   input  logic               clock,
   input  logic               reset,
   // input channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_motor_current,
   input  logic [15:0]        req_bus_voltage,
   input  logic [5:0]         req_current_setpoint,
   input  logic               req_reset_pressed,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_duty,
   output logic               rsp_motor_cut,
   output logic               rsp_fault_led,
   output logic [1:0]         rsp_mode,
   // configuration
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   picr_pkg::state_type state_ff, state_in;

   logic [14:0] limit_ff;
   logic [15:0] vmin_ff, vmax_ff, kp_ff, ki_ff;

   logic [1:0]         mode_ff;
   logic signed [23:0] integ_ff;
   logic [7:0]         held_ff;
   logic               led_ff;

   logic signed [15:0] cur_ff;
   logic [15:0]        vbus_ff;
   logic [5:0]         sp_ff;
   logic               button_ff;
   logic signed [16:0] err_ff;
   logic [17:0]        u_ff;
   logic [7:0]         res_duty_ff;
   logic               res_cut_ff;

   logic               rsp_valid_ff;
   logic [7:0]         rsp_duty_ff;
   logic               rsp_cut_ff;
   logic               rsp_led_ff;
   logic [1:0]         rsp_mode_ff;

   logic signed [picr_pkg::MUL_A_W-1:0] mul_a;
   logic signed [picr_pkg::MUL_B_W-1:0] mul_b;
   logic signed [picr_pkg::MUL_P_W-1:0] prod;

   logic               fault;
   logic [1:0]         eff_mode;
   logic signed [16:0] err_in;
   logic signed [24:0] step;
   logic signed [25:0] acc;
   logic signed [23:0] acc_sat;
   logic signed [25:0] u_sum;
   logic               run_done;
   logic [7:0]         run_duty;
   logic               bus_bad;
   logic               out_free;

   assign req_stall = (state_ff != picr_pkg::ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign fault    = $signed({cur_ff[15], cur_ff}) >= $signed({2'b00, limit_ff});
   assign eff_mode = fault ? picr_pkg::MODE_FAULT : mode_ff;
   assign err_in   = $signed({3'b000, sp_ff, 8'h00}) - $signed({cur_ff[15], cur_ff});

   // floor divide by 256 of the registered product
   assign step  = prod[32:8];
   assign acc   = $signed({step[24], step}) + $signed({{2{integ_ff[23]}}, integ_ff});
   assign u_sum = acc;

   always_comb begin
      if (acc > picr_pkg::INTEG_MAX) begin
         acc_sat = picr_pkg::INTEG_MAX[23:0];
      end else if (acc < picr_pkg::INTEG_MIN) begin
         acc_sat = picr_pkg::INTEG_MIN[23:0];
      end else begin
         acc_sat = acc[23:0];
      end
   end

   assign bus_bad = (vbus_ff <= vmin_ff) || (vbus_ff >= vmax_ff);

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         picr_pkg::ST_MULI: begin
            mul_a = {{(picr_pkg::MUL_A_W-17){err_ff[16]}}, err_ff};
            mul_b = {2'b00, ki_ff};
         end
         picr_pkg::ST_MULP: begin
            mul_a = {{(picr_pkg::MUL_A_W-17){err_ff[16]}}, err_ff};
            mul_b = {2'b00, kp_ff};
         end
         picr_pkg::ST_MULD: begin
            mul_a = {1'b0, u_ff};
            mul_b = {10'd0, picr_pkg::DUTY_FULL};
         end
         picr_pkg::ST_MULR: begin
            // u*150 >> 14 stays below 1350
            mul_a = {8'd0, prod[24:14]};
            mul_b = picr_pkg::RECIP9;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   picr_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (prod)
   );

   // run mode finishes either on a clamp in the sum step or after the divide by 9
   always_comb begin
      run_done = 1'b0;
      run_duty = 8'd0;
      state_in = state_ff;
      unique case (state_ff)
         picr_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = picr_pkg::ST_EVAL;
            end
         end
         picr_pkg::ST_EVAL: begin
            state_in = (eff_mode == picr_pkg::MODE_RUN) ? picr_pkg::ST_MULI
                                                        : picr_pkg::ST_OUT;
         end
         picr_pkg::ST_MULI: state_in = picr_pkg::ST_MULP;
         picr_pkg::ST_MULP: state_in = picr_pkg::ST_SUM;
         picr_pkg::ST_SUM: begin
            if (u_sum >= picr_pkg::CLAMP_U) begin
               run_done = 1'b1;
               run_duty = picr_pkg::DUTY_FULL;
               state_in = picr_pkg::ST_OUT;
            end else if (u_sum < 26'sd0) begin
               run_done = 1'b1;
               state_in = picr_pkg::ST_OUT;
            end else begin
               state_in = picr_pkg::ST_MULD;
            end
         end
         picr_pkg::ST_MULD: state_in = picr_pkg::ST_MULR;
         picr_pkg::ST_MULR: state_in = picr_pkg::ST_DIV;
         picr_pkg::ST_DIV: begin
            run_done = 1'b1;
            run_duty = prod[21:14];
            state_in = picr_pkg::ST_OUT;
         end
         picr_pkg::ST_OUT: begin
            if (out_free) begin
               state_in = picr_pkg::ST_IDLE;
            end
         end
         default: state_in = picr_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= picr_pkg::ST_IDLE;
         limit_ff     <= picr_pkg::CURRENT_LIMIT_RST;
         vmin_ff      <= picr_pkg::BUS_VMIN_RST;
         vmax_ff      <= picr_pkg::BUS_VMAX_RST;
         kp_ff        <= picr_pkg::PROP_GAIN_RST;
         ki_ff        <= picr_pkg::INTEG_GAIN_RST;
         mode_ff      <= picr_pkg::MODE_STOP;
         integ_ff     <= '0;
         held_ff      <= '0;
         led_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_we) begin
            unique case (csr_index)
               picr_pkg::CSR_CURRENT_LIMIT: limit_ff <= csr_wdata[14:0];
               picr_pkg::CSR_BUS_VMIN:      vmin_ff  <= csr_wdata;
               picr_pkg::CSR_BUS_VMAX:      vmax_ff  <= csr_wdata;
               picr_pkg::CSR_PROP_GAIN:     kp_ff    <= csr_wdata;
               picr_pkg::CSR_INTEG_GAIN:    ki_ff    <= csr_wdata;
               default: ;
            endcase
         end

         if (state_ff == picr_pkg::ST_EVAL) begin
            unique case (eff_mode)
               picr_pkg::MODE_RUN: begin
                  led_ff <= 1'b0;
               end
               picr_pkg::MODE_FAULT: begin
                  res_duty_ff <= 8'd0;
                  res_cut_ff  <= 1'b1;
                  if (button_ff) begin
                     mode_ff <= picr_pkg::MODE_STOP;
                     led_ff  <= 1'b0;
                  end else begin
                     mode_ff <= picr_pkg::MODE_FAULT;
                     led_ff  <= 1'b1;
                  end
               end
               default: begin
                  // stop, and the unused code treated as stop
                  res_duty_ff <= held_ff;
                  res_cut_ff  <= 1'b0;
                  mode_ff     <= button_ff ? picr_pkg::MODE_RUN : picr_pkg::MODE_STOP;
               end
            endcase
         end

         if (state_ff == picr_pkg::ST_MULP) begin
            integ_ff <= (sp_ff == 6'd0) ? 24'sd0 : acc_sat;
         end

         if (state_ff == picr_pkg::ST_SUM && u_sum >= picr_pkg::CLAMP_U) begin
            integ_ff <= picr_pkg::CLAMP_INTEG;
         end

         if (run_done) begin
            held_ff <= run_duty;
            if (bus_bad) begin
               res_duty_ff <= 8'd0;
               res_cut_ff  <= 1'b1;
               mode_ff     <= picr_pkg::MODE_STOP;
            end else begin
               res_duty_ff <= run_duty;
               res_cut_ff  <= 1'b0;
            end
         end

         if (state_ff == picr_pkg::ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (state_ff == picr_pkg::ST_IDLE && req_valid) begin
         cur_ff    <= req_motor_current;
         vbus_ff   <= req_bus_voltage;
         sp_ff     <= req_current_setpoint;
         button_ff <= req_reset_pressed;
      end
      if (state_ff == picr_pkg::ST_EVAL) begin
         err_ff <= err_in;
      end
      if (state_ff == picr_pkg::ST_SUM) begin
         u_ff <= u_sum[17:0];
      end
      if (state_ff == picr_pkg::ST_OUT && out_free) begin
         rsp_duty_ff <= res_duty_ff;
         rsp_cut_ff  <= res_cut_ff;
         rsp_led_ff  <= led_ff;
         rsp_mode_ff <= mode_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_duty      = rsp_duty_ff;
   assign rsp_motor_cut = rsp_cut_ff;
   assign rsp_fault_led = rsp_led_ff;
   assign rsp_mode      = rsp_mode_ff;

   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_duty_ff <= picr_pkg::DUTY_FULL)
      else $error("duty above full scale");

   a_cut_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_cut_ff |-> rsp_duty_ff == 8'd0)
      else $error("motor cut with nonzero duty");

   a_led_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_led_ff |-> rsp_mode_ff == picr_pkg::MODE_FAULT)
      else $error("fault lamp lit outside fault mode");

   a_mode_code: assert property (@(posedge clock) disable iff (reset)
      mode_ff == picr_pkg::MODE_RUN || mode_ff == picr_pkg::MODE_FAULT ||
      mode_ff == picr_pkg::MODE_STOP)
      else $error("unused mode code stored");

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == picr_pkg::ST_OUT && rsp_valid_ff && rsp_stall |=>
      state_ff == picr_pkg::ST_OUT)
      else $error("result dropped while output stalled");

endmodule

FILE: dv/tb.sv
// tb: self-checking bench for the pi current regulator with its fault latch
`timescale 1ns / 1ps

module tb;

   localparam longint CLAMP_Q12 = 36 * 4096;
   localparam longint DUTY_TOP = 150;
   localparam longint INTEG_HI = 8388607;
   localparam longint INTEG_LO = -8388608;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef struct packed {
      logic [7:0] duty;
      logic       cut;
      logic       led;
      logic [1:0] mode;
   } regulator_word_type;

   // mirror of the loop: registers, state, and the words still owed by the block
   class loop_tracker;
      logic [14:0] trip_level;
      logic [15:0] vbus_low;
      logic [15:0] vbus_high;
      logic [15:0] kp;
      logic [15:0] ki_dt;
      logic [1:0]  mode_now;
      longint      integ;
      logic [7:0]  duty_held;
      bit          lamp;
      regulator_word_type predicted_words[$];
      int unsigned mismatches;

      function new();
         trip_level = picr_pkg::CURRENT_LIMIT_RST;
         vbus_low   = picr_pkg::BUS_VMIN_RST;
         vbus_high  = picr_pkg::BUS_VMAX_RST;
         kp         = picr_pkg::PROP_GAIN_RST;
         ki_dt      = picr_pkg::INTEG_GAIN_RST;
         mode_now   = picr_pkg::MODE_STOP;
         integ      = 0;
         duty_held  = '0;
         lamp       = 1'b0;
         mismatches = 0;
      endfunction

      function void set_reg(logic [2:0] idx, logic [15:0] value);
         case (idx)
            picr_pkg::CSR_CURRENT_LIMIT: trip_level = value[14:0];
            picr_pkg::CSR_BUS_VMIN:      vbus_low = value;
            picr_pkg::CSR_BUS_VMAX:      vbus_high = value;
            picr_pkg::CSR_PROP_GAIN:     kp = value;
            picr_pkg::CSR_INTEG_GAIN:    ki_dt = value;
            default: ;
         endcase
      endfunction

      function void predict_sample(logic signed [15:0] cur, logic [15:0] vbus,
                                   logic [5:0] sp, bit btn);
         longint c;
         longint err;
         longint acc;
         longint u;
         longint d;
         regulator_word_type w;
         c = longint'(cur);
         w = '0;
         if (c >= longint'(trip_level)) mode_now = picr_pkg::MODE_FAULT;
         case (mode_now)
            picr_pkg::MODE_RUN: begin
               err = longint'(sp) * 256 - c;
               lamp = 1'b0;
               if (sp != 0) begin
                  // arithmetic shift floors the q8.8 product
                  acc = integ + ((err * longint'(ki_dt)) >>> 8);
                  if (acc > INTEG_HI) acc = INTEG_HI;
                  if (acc < INTEG_LO) acc = INTEG_LO;
                  integ = acc;
               end else begin
                  integ = 0;
               end
               u = ((err * longint'(kp)) >>> 8) + integ;
               if (u >= CLAMP_Q12) begin
                  d = DUTY_TOP;
                  integ = CLAMP_Q12;
               end else if (u < 0) begin
                  d = 0;
               end else begin
                  d = (u * DUTY_TOP) / CLAMP_Q12;
               end
               duty_held = d[7:0];
               w.duty = d[7:0];
               if (vbus <= vbus_low || vbus >= vbus_high) begin
                  w.cut = 1'b1;
                  w.duty = '0;
                  mode_now = picr_pkg::MODE_STOP;
               end
            end
            picr_pkg::MODE_FAULT: begin
               w.cut = 1'b1;
               lamp = 1'b1;
               if (btn) begin
                  mode_now = picr_pkg::MODE_STOP;
                  lamp = 1'b0;
               end
            end
            default: begin
               mode_now = picr_pkg::MODE_STOP;
               w.duty = duty_held;
               if (btn) mode_now = picr_pkg::MODE_RUN;
            end
         endcase
         w.led = lamp;
         w.mode = mode_now;
         predicted_words.push_back(w);
      endfunction

      function void report(string what, logic [7:0] want, logic [7:0] got);
         mismatches++;
         $display("%0t %s mismatch: expected %0d actual %0d", $time, what, want, got);
      endfunction

      function void check_word(regulator_word_type got);
         regulator_word_type want;
         if (predicted_words.size() == 0) begin
            mismatches++;
            $display("%0t word with none owed: expected none actual duty %0d mode %0d",
                     $time, got.duty, got.mode);
            return;
         end
         want = predicted_words.pop_front();
         if (got.duty !== want.duty) report("duty", want.duty, got.duty);
         if (got.cut !== want.cut) report("motor_cut", 8'(want.cut), 8'(got.cut));
         if (got.led !== want.led) report("fault_led", 8'(want.led), 8'(got.led));
         if (got.mode !== want.mode) report("mode", 8'(want.mode), 8'(got.mode));
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [15:0] req_motor_current;
   logic [15:0]        req_bus_voltage;
   logic [5:0]         req_current_setpoint;
   logic               req_reset_pressed;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [7:0]         rsp_duty;
   logic               rsp_motor_cut;
   logic               rsp_fault_led;
   logic [1:0]         rsp_mode;
   logic               csr_we;
   logic [2:0]         csr_index;
   logic [15:0]        csr_wdata;

   loop_tracker tracker;
   bit no_idle = 1'b0;
   int idle_cycles = 0;

   pi_current_regulator_with_fault_latch_core dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_motor_current    (req_motor_current),
      .req_bus_voltage      (req_bus_voltage),
      .req_current_setpoint (req_current_setpoint),
      .req_reset_pressed    (req_reset_pressed),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_duty             (rsp_duty),
      .rsp_motor_cut        (rsp_motor_cut),
      .rsp_fault_led        (rsp_fault_led),
      .rsp_mode             (rsp_mode),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // result side: after each accepted word hold stall for a random count
   initial begin
      int unsigned hold;
      hold = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            hold = no_idle ? 0 : $urandom_range(0, 18);
            if (hold > 0) rsp_stall <= 1'b1;
         end else if (hold > 0) begin
            hold--;
            if (hold == 0) rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_word('{duty: rsp_duty, cut: rsp_motor_cut,
                              led: rsp_fault_led, mode: rsp_mode});
   end

   always @(posedge clock) begin
      if (reset || csr_we || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL pi_current_regulator_with_fault_latch_core");
         $finish;
      end
   end

   // valid stays high across back-to-back words, it only drops for a gap or a drain
   task automatic send_sample(input logic signed [15:0] cur, input logic [15:0] vbus,
                              input logic [5:0] sp, input bit btn);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_motor_current    <= cur;
      req_bus_voltage      <= vbus;
      req_current_setpoint <= sp;
      req_reset_pressed    <= btn;
      do @(posedge clock); while (req_stall);
      tracker.predict_sample(cur, vbus, sp, btn);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (tracker.predicted_words.size() != 0);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      tracker.set_reg(idx, value);
   endtask

   task automatic program_loop(input logic [15:0] limit, input logic [15:0] vmin,
                               input logic [15:0] vmax, input logic [15:0] pgain,
                               input logic [15:0] igain);
      drain_results();
      repeat (10) @(posedge clock);
      write_reg(picr_pkg::CSR_CURRENT_LIMIT, limit);
      write_reg(picr_pkg::CSR_BUS_VMIN, vmin);
      write_reg(picr_pkg::CSR_BUS_VMAX, vmax);
      write_reg(picr_pkg::CSR_PROP_GAIN, pgain);
      write_reg(picr_pkg::CSR_INTEG_GAIN, igain);
      csr_we <= 1'b0;
   endtask

   // fault -> stop -> run on button presses; the lowest current never trips
   task automatic reach_run();
      while (tracker.mode_now != picr_pkg::MODE_RUN)
         send_sample(16'sh8000, 16'd30000, 6'd20, 1'b1);
   endtask

   task automatic send_random_sample();
      int pick;
      int c;
      int lim;
      int lo;
      int hi;
      logic [15:0] vbus;
      logic [5:0] sp;
      bit btn;
      pick = $urandom_range(0, 99);
      lim = int'(tracker.trip_level);
      lo = int'(tracker.vbus_low);
      hi = int'(tracker.vbus_high);
      sp = 6'($urandom_range(0, 63));
      if ($urandom_range(0, 9) == 0) sp = '0;
      // well-formed: current near the setpoint, below the trip level, bus in window if it has room
      c = int'(sp) * 256 + int'($urandom_range(0, 4095)) - 2048;
      if (c >= lim) c = lim - 1 - int'($urandom_range(0, 2047));
      if (c < -32768) c = -32768;
      vbus = (hi > lo + 1) ? 16'($urandom_range(lo + 1, hi - 1))
                           : 16'($urandom_range(0, 65535));
      case (tracker.mode_now)
         picr_pkg::MODE_STOP:  btn = 1'($urandom_range(0, 1));
         picr_pkg::MODE_FAULT: btn = ($urandom_range(0, 2) == 0);
         default:              btn = ($urandom_range(0, 9) == 0);
      endcase
      if (pick < 12) begin
         c = int'($urandom_range(0, 65535)) - 32768;
         vbus = 16'($urandom_range(0, 65535));
         sp = 6'($urandom_range(0, 63));
         btn = 1'($urandom_range(0, 1));
      end else if (pick < 18) begin
         c = lim + int'($urandom_range(0, 32767 - lim));
      end else if (pick < 25) begin
         vbus = $urandom_range(0, 1) ? 16'($urandom_range(0, lo))
                                     : 16'($urandom_range(hi, 65535));
      end
      send_sample(c[15:0], vbus, sp, btn);
   endtask

   task automatic run_random(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
         if (i == count / 2) drain_results();
         send_random_sample();
      end
      no_idle = 1'b0;
   endtask

   task automatic run_directed();
      send_sample(16'sd0, 16'd11000, 6'd10, 1'b0);     // stop, held duty
      send_sample(16'sd0, 16'd11000, 6'd10, 1'b1);     // stop to run
      send_sample(16'sd0, 16'd11000, 6'd0, 1'b0);      // zero setpoint clears integral
      send_sample(16'sh8000, 16'd11000, 6'd63, 1'b0);  // upper clamp
      send_sample(16'sd6399, 16'd11000, 6'd63, 1'b0);
      send_sample(16'sd6399, 16'd11000, 6'd63, 1'b0);
      send_sample(16'sd6399, 16'd11000, 6'd1, 1'b0);   // negative command by the second word
      send_sample(16'sd6399, 16'd11000, 6'd1, 1'b0);
      send_sample(16'sd256, 16'd9728, 6'd20, 1'b0);    // bus at the low limit
      send_sample(16'sd0, 16'd11000, 6'd20, 1'b1);
      send_sample(16'sd256, 16'd13312, 6'd20, 1'b0);   // bus at the high limit
      send_sample(16'sd0, 16'd0, 6'd20, 1'b1);
      send_sample(16'sd256, 16'hffff, 6'd20, 1'b0);
      send_sample(16'sd0, 16'd11000, 6'd20, 1'b1);
      send_sample(16'sh7fff, 16'd11000, 6'd20, 1'b0);  // overcurrent latches fault
      send_sample(16'sd0, 16'd11000, 6'd20, 1'b0);
      send_sample(16'sd0, 16'd11000, 6'd20, 1'b1);     // fault to stop
      send_sample(16'sd6400, 16'd11000, 6'd20, 1'b1);  // trip and release in one word
      send_sample(16'sd0, 16'd11000, 6'd20, 1'b1);
      send_sample(16'sd6400, 16'd11000, 6'd20, 1'b0);  // trip from run
      send_sample(16'sd0, 16'd11000, 6'd20, 1'b1);
      send_sample(16'sd0, 16'd9729, 6'd40, 1'b1);
      send_sample(16'sd0, 16'd9729, 6'd40, 1'b0);      // just inside the window
   endtask

   initial begin
      logic [15:0] lim;
      logic [15:0] vmin;
      logic [15:0] vmax;
      tracker = new();
      reset                <= 1'b1;
      req_valid            <= 1'b0;
      req_motor_current    <= '0;
      req_bus_voltage      <= '0;
      req_current_setpoint <= '0;
      req_reset_pressed    <= 1'b0;
      csr_we               <= 1'b0;
      csr_index            <= picr_pkg::CSR_CURRENT_LIMIT;
      csr_wdata            <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      run_random(300);

      // top of limit and gains, widest bus window; drive the integral into both rails
      program_loop(16'hffff, 16'd0, 16'hffff, 16'hffff, 16'hffff);
      reach_run();
      repeat (3) send_sample(16'sd32766, 16'd30000, 6'd1, 1'b0);
      repeat (2) send_sample(16'sh8000, 16'd30000, 6'd63, 1'b0);
      run_random(300);

      // bottom of every range: empty bus window, zero gains, trip at zero
      program_loop(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      run_random(200);

      repeat (3) begin
         lim = 16'($urandom_range(1024, 16000));
         lim[15] = 1'($urandom_range(0, 1));
         vmin = 16'($urandom_range(0, 20000));
         vmax = vmin + 16'($urandom_range(2, 30000));
         program_loop(lim, vmin, vmax, 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 65535)));
         run_random(330);
      end

      drain_results();
      repeat (20) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.predicted_words.size() == 0)
         $display("PASS pi_current_regulator_with_fault_latch_core");
      else
         $display("FAIL pi_current_regulator_with_fault_latch_core");
      $finish;
   end

endmodule
